### src/hrp_pkg.sv
// ============================================================================
// hrp_pkg: shared types, constants and functions of the HTTP header parser
// Holds the channel payload types, the queue entry type, the parser context,
// the byte classifier and the per-byte update of the status and header
// state.
// ============================================================================
package hrp_pkg;

    // Default widths of the saturating length value and header line counter.
    localparam int LENGTH_BITS_DEF = 32;
    localparam int COUNT_BITS_DEF  = 8;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Characters that the parser reacts to.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Saturation limits of the fixed-width fields.
    localparam logic [9:0]  STATUS_MAX = 10'd999;
    localparam logic [15:0] REASON_MAX = 16'hFFFF;

    // Key matching: length of the key text and the code for a failed match.
    localparam logic [3:0] KEY_LEN  = 4'd14;
    localparam logic [3:0] KEY_MISS = 4'd15;

    // Progress inside a Content-Length value.
    localparam logic [1:0] VS_KEY    = 2'd0;
    localparam logic [1:0] VS_BLANK  = 2'd1;
    localparam logic [1:0] VS_DIGITS = 2'd2;

    // Parser phases, one-hot.
    typedef enum logic [6:0] {
        PH_VERSION     = 7'b0000001,
        PH_CODE        = 7'b0000010,
        PH_CODE_TAIL   = 7'b0000100,
        PH_REASON_LEAD = 7'b0001000,
        PH_REASON      = 7'b0010000,
        PH_HEADERS     = 7'b0100000,
        PH_DONE        = 7'b1000000
    } phase_t;

    // Input beat.
    typedef struct packed {
        logic [7:0] byte_value;
        logic       message_start;
    } item_t;

    // Output beat.
    typedef struct packed {
        logic [9:0]  resp_status;
        logic [7:0]  header_count;
        logic [31:0] content_length;
        logic        length_seen;
        logic [15:0] reason_length;
    } result_t;

    // Byte with its character class flags.
    typedef struct packed {
        logic [7:0] value;
        logic       is_digit;
        logic       is_blank;
        logic       is_space;
        logic       is_colon;
        logic [3:0] digit;
    } byte_class_t;

    // Queue entry: one operation for the back end per accepted byte.
    typedef struct packed {
        logic        msg_start;
        logic        pre_cr;
        logic        line_end;
        logic        has_byte;
        byte_class_t cls;
    } op_t;

    // Parser context apart from the parameter-wide counters.
    typedef struct packed {
        phase_t      phase;
        logic [9:0]  status;
        logic [15:0] reason;
        logic        line_empty;
        logic [3:0]  key_pos;
        logic [1:0]  value_step;
        logic        length_found;
        logic        acc_digit;
        logic        start_value;
    } ctx_t;

    localparam ctx_t CTX_RESET = '{
        phase:        PH_VERSION,
        status:       10'd0,
        reason:       16'd0,
        line_empty:   1'b1,
        key_pos:      4'd0,
        value_step:   VS_KEY,
        length_found: 1'b0,
        acc_digit:    1'b0,
        start_value:  1'b0
    };

    // Character class of one byte.
    function automatic byte_class_t classify(logic [7:0] b);
        byte_class_t r;
        r.value    = b;
        r.is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
        r.is_space = (b == CH_SPACE);
        r.is_blank = (b == CH_SPACE) || (b == CH_TAB);
        r.is_colon = (b == CH_COLON);
        r.digit    = b[3:0];
        return r;
    endfunction

    // Characters of the Content-Length key.
    function automatic logic [7:0] key_char(logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = "C";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "L";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Effect of one content byte on the parser context. The flags acc_digit
    // and start_value tell the caller how to update the length value.
    function automatic ctx_t content_step(ctx_t s, byte_class_t c);
        ctx_t        r;
        logic [13:0] code_wide;
        logic [1:0]  vs;
        r             = s;
        r.acc_digit   = 1'b0;
        r.start_value = 1'b0;
        code_wide     = 14'(s.status) * 14'd10 + 14'(c.digit);
        vs            = s.value_step;
        case (s.phase)
            PH_VERSION:
            begin
                if (c.is_space)
                begin
                    r.phase = PH_CODE;
                end
            end
            PH_CODE:
            begin
                if (c.is_space)
                begin
                    r.phase = PH_REASON_LEAD;
                end
                else if (c.is_digit)
                begin
                    r.status = (code_wide > 14'(STATUS_MAX)) ? STATUS_MAX : code_wide[9:0];
                end
                else
                begin
                    r.phase = PH_CODE_TAIL;
                end
            end
            PH_CODE_TAIL:
            begin
                if (c.is_space)
                begin
                    r.phase = PH_REASON_LEAD;
                end
            end
            PH_REASON_LEAD:
            begin
                if (!c.is_blank)
                begin
                    r.phase = PH_REASON;
                    if (s.reason != REASON_MAX)
                    begin
                        r.reason = s.reason + 16'd1;
                    end
                end
            end
            PH_REASON:
            begin
                if (s.reason != REASON_MAX)
                begin
                    r.reason = s.reason + 16'd1;
                end
            end
            PH_HEADERS:
            begin
                r.line_empty = 1'b0;
                // Blanks ahead of a length value are skipped.
                if (!(vs == VS_BLANK && c.is_blank))
                begin
                    if (vs == VS_BLANK)
                    begin
                        vs = VS_DIGITS;
                    end
                    if (vs == VS_DIGITS)
                    begin
                        r.acc_digit  = c.is_digit;
                        r.value_step = c.is_digit ? VS_DIGITS : VS_KEY;
                    end
                    else if (s.key_pos < KEY_LEN)
                    begin
                        r.key_pos = (c.value == key_char(s.key_pos)) ?
                                    s.key_pos + 4'd1 : KEY_MISS;
                    end
                    else if (s.key_pos == KEY_LEN && c.is_colon)
                    begin
                        r.length_found = 1'b1;
                        r.start_value  = 1'b1;
                        r.value_step   = VS_BLANK;
                        r.key_pos      = KEY_MISS;
                    end
                end
            end
            default:
            begin
                r = s;
                r.acc_digit   = 1'b0;
                r.start_value = 1'b0;
            end
        endcase
        return r;
    endfunction

endpackage

### src/hrp_front.sv
// ============================================================================
// hrp_front: byte intake and line-ending classification
// Accepts one byte per beat, pairs CR with a following LF, classifies the
// byte and pushes one operation per beat into the queue.
// ============================================================================
module hrp_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  hrp_pkg::item_t  item,
    output logic            push_valid,
    input  logic            push_ready,
    output hrp_pkg::op_t    push_op
);

    logic cr_pending_reg;
    logic cr_pending_next;
    logic pending;
    logic is_cr;
    logic is_lf;
    logic accept;

    assign item_ready = push_ready;
    assign push_valid = item_valid;
    assign accept     = item_valid && push_ready;

    // A message start drops any CR held from the previous message.
    assign pending = cr_pending_reg && !item.message_start;
    assign is_cr   = (item.byte_value == hrp_pkg::CH_CR);
    assign is_lf   = (item.byte_value == hrp_pkg::CH_LF);

    // Build the operation: either a line end, or an optional held CR
    // followed by an optional content byte.
    always_comb
    begin
        push_op.msg_start = item.message_start;
        push_op.cls       = hrp_pkg::classify(item.byte_value);
        push_op.line_end  = 1'b0;
        push_op.pre_cr    = 1'b0;
        push_op.has_byte  = 1'b0;
        cr_pending_next   = 1'b0;
        if (pending && is_lf)
        begin
            push_op.line_end = 1'b1;
        end
        else
        begin
            push_op.pre_cr   = pending;
            push_op.has_byte = !is_cr;
            cr_pending_next  = is_cr;
        end
    end

    // Held CR flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cr_pending_reg <= 1'b0;
        end
        else if (accept)
        begin
            cr_pending_reg <= cr_pending_next;
        end
    end

endmodule

### src/hrp_queue.sv
// ============================================================================
// hrp_queue: short operation queue between front and back
// A small register FIFO that lets the intake and the parser stall apart.
// ============================================================================
module hrp_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  hrp_pkg::op_t  push_op,
    output logic          pop_valid,
    input  logic          pop_ready,
    output hrp_pkg::op_t  pop_op
);

    localparam int DEPTH = hrp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    hrp_pkg::op_t     entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Occupancy after this cycle's push and pop.
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

### src/hrp_back.sv
// ============================================================================
// hrp_back: parser state update and result register
// Applies one queued operation per cycle while no result stalls, to the
// status line and header state; loads the result register at the empty line.
// ============================================================================
module hrp_back
#(
    parameter int LENGTH_BITS = hrp_pkg::LENGTH_BITS_DEF,
    parameter int COUNT_BITS  = hrp_pkg::COUNT_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  hrp_pkg::op_t      pop_op,
    output logic              result_valid,
    input  logic              result_ready,
    output hrp_pkg::result_t  result
);

    localparam int PROD_W = LENGTH_BITS + 4;

    hrp_pkg::ctx_t          ctx_reg;
    hrp_pkg::ctx_t          ctx_next;
    hrp_pkg::ctx_t          ctx_base;
    hrp_pkg::ctx_t          ctx_cr;
    hrp_pkg::ctx_t          ctx_byte;
    logic [COUNT_BITS-1:0]  lines_reg;
    logic [COUNT_BITS-1:0]  lines_next;
    logic [COUNT_BITS-1:0]  lines_base;
    logic [LENGTH_BITS-1:0] length_reg;
    logic [LENGTH_BITS-1:0] length_next;
    logic [LENGTH_BITS-1:0] length_base;
    logic [PROD_W-1:0]      length_prod;
    logic [15:0]            lines_wide;
    logic [63:0]            length_wide;
    logic                   emit;
    logic                   do_pop;
    logic                   result_valid_reg;
    hrp_pkg::result_t       result_reg;
    hrp_pkg::result_t       result_next;

    assign pop_ready    = !result_valid_reg || result_ready;
    assign do_pop       = pop_valid && pop_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // State the operation starts from: a message start clears everything.
    assign ctx_base    = pop_op.msg_start ? hrp_pkg::CTX_RESET : ctx_reg;
    assign lines_base  = pop_op.msg_start ? '0 : lines_reg;
    assign length_base = pop_op.msg_start ? '0 : length_reg;

    // A held CR counts as content ahead of the byte that follows it.
    assign ctx_cr   = pop_op.pre_cr ?
                      hrp_pkg::content_step(ctx_base, hrp_pkg::classify(hrp_pkg::CH_CR)) :
                      ctx_base;
    assign ctx_byte = pop_op.has_byte ? hrp_pkg::content_step(ctx_cr, pop_op.cls) : ctx_cr;

    // Length times ten plus the digit, with headroom to spot overflow.
    assign length_prod = (PROD_W'(length_base) << 3) + (PROD_W'(length_base) << 1)
                       + PROD_W'(pop_op.cls.digit);

    // Next parser state.
    always_comb
    begin
        ctx_next    = ctx_base;
        lines_next  = lines_base;
        length_next = length_base;
        emit        = 1'b0;
        if (ctx_base.phase == hrp_pkg::PH_DONE)
        begin
            ctx_next = ctx_base;
        end
        else if (pop_op.line_end)
        begin
            if (ctx_base.phase != hrp_pkg::PH_HEADERS)
            begin
                ctx_next.phase      = hrp_pkg::PH_HEADERS;
                ctx_next.line_empty = 1'b1;
                ctx_next.key_pos    = 4'd0;
                ctx_next.value_step = hrp_pkg::VS_KEY;
            end
            else if (ctx_base.line_empty)
            begin
                ctx_next.phase = hrp_pkg::PH_DONE;
                emit           = 1'b1;
            end
            else
            begin
                if (lines_base != '1)
                begin
                    lines_next = lines_base + COUNT_BITS'(1);
                end
                ctx_next.line_empty = 1'b1;
                ctx_next.key_pos    = 4'd0;
                ctx_next.value_step = hrp_pkg::VS_KEY;
            end
        end
        else
        begin
            ctx_next             = ctx_byte;
            ctx_next.acc_digit   = 1'b0;
            ctx_next.start_value = 1'b0;
            if (ctx_byte.start_value)
            begin
                length_next = '0;
            end
            else if (ctx_byte.acc_digit)
            begin
                length_next = (|length_prod[PROD_W-1:LENGTH_BITS]) ?
                              '1 : length_prod[LENGTH_BITS-1:0];
            end
        end
    end

    // Result fields, narrowed or widened to the output widths.
    assign lines_wide  = 16'(lines_base);
    assign length_wide = 64'(length_base);

    always_comb
    begin
        result_next.resp_status    = ctx_base.status;
        result_next.header_count   = lines_wide[7:0];
        result_next.content_length = length_wide[31:0];
        result_next.length_seen    = ctx_base.length_found;
        result_next.reason_length  = ctx_base.reason;
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg    <= hrp_pkg::CTX_RESET;
            lines_reg  <= '0;
            length_reg <= '0;
        end
        else if (do_pop)
        begin
            ctx_reg    <= ctx_next;
            lines_reg  <= lines_next;
            length_reg <= length_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (do_pop && emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (do_pop && emit)
        begin
            result_reg <= result_next;
        end
    end

endmodule

### src/http_response_header_parser.sv
// ============================================================================
// http_response_header_parser: HTTP/1.1 response header parser
// Reads a response one byte per beat and reports the status code, header
// line count, Content-Length value and reason length at the empty line.
// ============================================================================
// Usage:
// The item channel takes one byte of the response per beat. Set
// message_start on the first byte of each response; it clears all parser
// state before that byte is used. The result channel carries one beat per
// response, produced by the empty line that closes the header. Bytes after
// that are ignored until the next message start.
// Throughput is one byte per cycle, set by the state update in the back
// end, while the result receiver does not stall. The operation of the
// final LF waits in the front-to-back queue and is then loaded into the
// result register, which raises result_valid.
// After reset the parser waits for the status line of a new response and
// the channels hold no beats. When the receiver stalls, the result stays in
// its register; the two-entry queue keeps taking bytes until it fills, and
// only then does item_ready drop.
module http_response_header_parser
#(
    parameter int LENGTH_BITS = hrp_pkg::LENGTH_BITS_DEF,
    parameter int COUNT_BITS  = hrp_pkg::COUNT_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  hrp_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_ready,
    output hrp_pkg::result_t  result
);

    logic         push_valid;
    logic         push_ready;
    hrp_pkg::op_t push_op;
    logic         pop_valid;
    logic         pop_ready;
    hrp_pkg::op_t pop_op;

    // Byte intake and CR/LF pairing.
    hrp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op)
    );

    // Operation queue.
    hrp_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op)
    );

    // Parser state and result register.
    hrp_back
    #(
        .LENGTH_BITS (LENGTH_BITS),
        .COUNT_BITS  (COUNT_BITS)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_op       (pop_op),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

### src/hrp_checker.sv
// ============================================================================
// hrp_checker: port-level checks of the HTTP header parser
// Watches the top level's channels and flags behavior that the parser must
// never show.
// ============================================================================
module hrp_checker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_ready,
    input  hrp_pkg::item_t    item,
    input  logic              result_valid,
    input  logic              result_ready,
    input  hrp_pkg::result_t  result
);

    // A stalled result beat holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

    // The queue only fills through an accepted byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(item_ready) |-> $past(item_valid))
    else $error("item_ready dropped without an accepted byte");

    // The status code saturates at 999.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.resp_status <= hrp_pkg::STATUS_MAX)
    else $error("status code above saturation limit");

    // A length value only exists when a Content-Length line was found.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.length_seen |-> result.content_length == 32'd0)
    else $error("content length without a Content-Length header");

endmodule

bind http_response_header_parser hrp_checker u_hrp_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
